[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside of reset.
`define CHC_ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("chc assertion failed");

// Checks that a condition in one cycle is followed by another in the next cycle.
`define CHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("chc assertion failed");

`endif

[design/chc_pkg.sv]
package chc_pkg;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_FETCH,
    ST_SCAN,
    ST_SYM,
    ST_CONV
  } chc_state_e;

endpackage

[design/chc_if.sv]
interface chc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_value;

  modport source (output valid, output action, output byte_value, input ready);
  modport sink (input valid, input action, input byte_value, output ready);
endinterface

interface chc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       end_of_text;

  modport source (output valid, output out_char, output end_of_text, input ready);
  modport sink (input valid, input out_char, input end_of_text, output ready);
endinterface

[design/chc_ram.sv]
module chc_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/chc_bcd.sv]
module chc_bcd #(
  parameter int COUNT_BITS = 11,
  parameter int NUM_DIGITS = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [COUNT_BITS-1:0]   value_i,
  output logic                    done_o,
  output logic [4*NUM_DIGITS-1:0] digits_o
);

  localparam int CW = $clog2(COUNT_BITS + 1);

  logic [COUNT_BITS-1:0]   bin_q;
  logic [4*NUM_DIGITS-1:0] bcd_q, bcd_adj;
  logic [CW-1:0]           cnt_q;
  logic                    busy_q;

  // Double dabble: one input bit per cycle, MSB first.
  always_comb begin
    bcd_adj = bcd_q;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(COUNT_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[COUNT_BITS-2:0], 1'b0};
      bcd_q <= {bcd_adj[4*NUM_DIGITS-2:0], bin_q[COUNT_BITS-1]};
    end
  end

  assign done_o   = ~busy_q;
  assign digits_o = bcd_q;

endmodule

[design/char_histogram_count_text.sv]
// A digit word is registered from the fetch state once the output register is free. A symbol
// or end marker follows a scan of the bins (one per cycle); a finished scan sends the marker from fetch.
// An add reads the RAM in idle and writes it in the add state, a skipped byte stays in idle, and
// a symbol waits in the conversion state for the serial decimal conversion of its count.
// A result word held by the receiver stalls the next fetch until it is taken.
// Reset clears all bin valid flags at once, so the histogram reads empty right after reset.
module char_histogram_count_text import chc_pkg::*; #(
  parameter int COUNT_BITS = 11,
  parameter int NUM_BINS   = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  chc_in_if.sink     in_i,
  chc_out_if.source  out_o
);

  localparam int AW  = $clog2(NUM_BINS);
  localparam int PW  = $clog2(NUM_BINS + 1);
  localparam int ND  = (COUNT_BITS * 1233) / 4096 + 1;
  localparam int DLW = $clog2(ND + 1);
  localparam int BW  = 4 * ND;

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [PW-1:0]         SCAN_END = PW'(NUM_BINS);

  chc_state_e state_q, state_d;

  logic [NUM_BINS-1:0]   valid_q, valid_d;
  logic [AW-1:0]         rd_addr_q, ram_raddr, ram_waddr;
  logic                  ram_we;
  logic [COUNT_BITS-1:0] ram_rdata, ram_wdata, rd_cnt;
  logic [PW-1:0]         scan_q, scan_d, scan_inc;
  logic [DLW-1:0]        dleft_q, dleft_d, dsel, bcd_len;
  logic [BW-1:0]         digits_q, digits_d, digits_shift, bcd_digits;
  logic [7:0]            sym_q, sym_d, digit_char;
  logic                  bcd_start, bcd_done;
  logic                  out_valid_q, out_valid_d, out_end_q, out_end_d;
  logic [7:0]            out_char_q, out_char_d;
  logic                  in_fire, out_free, is_blank, in_range, add_ok;

  chc_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_chc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  chc_bcd #(.COUNT_BITS(COUNT_BITS), .NUM_DIGITS(ND)) u_chc_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bcd_start),
    .value_i  (rd_cnt),
    .done_o   (bcd_done),
    .digits_o (bcd_digits)
  );

  assign in_fire  = in_i.valid && (state_q == ST_IDLE);
  assign out_free = ~out_valid_q | out_o.ready;
  assign is_blank = (in_i.byte_value == CHR_SPACE) || (in_i.byte_value == CHR_TAB) ||
                    (in_i.byte_value == CHR_LF) || (in_i.byte_value == CHR_CR);
  assign in_range = ({1'b0, in_i.byte_value} < 9'(NUM_BINS));
  assign add_ok   = (in_i.action == ACT_ADD) && !is_blank && in_range;

  // A bin whose valid flag is clear holds zero, whatever the RAM says.
  assign rd_cnt   = valid_q[rd_addr_q] ? ram_rdata : '0;
  assign scan_inc = scan_q + 1'b1;

  assign dsel         = dleft_q - 1'b1;
  assign digits_shift = digits_q >> {dsel, 2'b00};
  assign digit_char   = CHR_ZERO + {4'b0000, digits_shift[3:0]};

  always_comb begin
    bcd_len = '0;
    for (int k = 0; k < ND; k++) begin
      if (bcd_digits[4*k +: 4] != 4'd0) begin
        bcd_len = DLW'(k + 1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.action == ACT_FETCH) begin
            state_d = ST_FETCH;
          end else if (add_ok) begin
            state_d = ST_ADD;
          end
        end
      end
      ST_ADD: state_d = ST_IDLE;
      ST_FETCH: begin
        if (dleft_q != '0 || scan_q == SCAN_END) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_cnt != '0) begin
          state_d = ST_SYM;
        end else if (scan_inc == SCAN_END) begin
          state_d = ST_FETCH;
        end
      end
      ST_SYM: begin
        if (out_free) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = rd_addr_q;
    ram_wdata   = rd_cnt + 1'b1;
    ram_raddr   = rd_addr_q;
    valid_d     = valid_q;
    bcd_start   = 1'b0;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_char_d  = out_char_q;
    out_end_d   = out_end_q;
    scan_d      = scan_q;
    dleft_d     = dleft_q;
    digits_d    = digits_q;
    sym_d       = sym_q;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        ram_raddr  = in_i.byte_value[AW-1:0];
      end
      ST_ADD: begin
        if (rd_cnt != CNT_MAX) begin
          ram_we             = 1'b1;
          valid_d[rd_addr_q] = 1'b1;
        end
      end
      ST_FETCH: begin
        if (dleft_q != '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_char_d  = digit_char;
            out_end_d   = 1'b0;
            dleft_d     = dsel;
          end
        end else if (scan_q == SCAN_END) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_char_d  = CHR_NUL;
            out_end_d   = 1'b1;
            scan_d      = '0;
          end
        end else begin
          ram_raddr = scan_q[AW-1:0];
        end
      end
      ST_SCAN: begin
        ram_raddr = scan_inc[AW-1:0];
        scan_d    = scan_inc;
        if (rd_cnt != '0) begin
          valid_d[rd_addr_q] = 1'b0;
          bcd_start          = 1'b1;
          sym_d              = 8'(rd_addr_q);
        end
      end
      ST_SYM: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sym_q;
          out_end_d   = 1'b0;
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          digits_d = bcd_digits;
          dleft_d  = bcd_len;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      scan_q      <= '0;
      dleft_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      scan_q      <= scan_d;
      dleft_q     <= dleft_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= ram_raddr;
    digits_q   <= digits_d;
    sym_q      <= sym_d;
    out_char_q <= out_char_d;
    out_end_q  <= out_end_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_char    = out_char_q;
  assign out_o.end_of_text = out_end_q;

endmodule

[design/chc_checker.sv]
`include "assert_macros.svh"

module chc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_action_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_char_i,
  input logic       end_of_text_i
);

  logic [1:0] pend_q, pend_d;
  logic       fetch_fire, out_fire;

  assign fetch_fire = in_valid_i && in_ready_i && in_action_i;
  assign out_fire   = out_valid_i && out_ready_i;

  // Fetch words accepted whose result word has not yet been taken.
  always_comb begin
    pend_d = pend_q;
    if (fetch_fire && !out_fire) begin
      pend_d = pend_q + 2'd1;
    end else if (!fetch_fire && out_fire) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `CHC_ASSERT_RST(a_no_unrequested_word, clk_i, rst_ni, out_valid_i |-> pend_q != 2'd0)
  `CHC_ASSERT_RST(a_pending_bound, clk_i, rst_ni, pend_q != 2'd3)
  `CHC_ASSERT_RST(a_end_marker_zero, clk_i, rst_ni, out_valid_i && end_of_text_i |-> out_char_i == 8'd0)
  `CHC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_char_i) && $stable(end_of_text_i))

endmodule

bind char_histogram_count_text chc_checker u_chc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_action_i   (in_i.action),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_char_i    (out_o.out_char),
  .end_of_text_i (out_o.end_of_text)
);

[sim/char_histogram_count_text_checker.sv]
module char_histogram_count_text_checker import chc_pkg::*; #(
  parameter int COUNT_BITS = 11,
  parameter int NUM_BINS   = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  chc_in_if    in_i,
  chc_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   markers_due_o,
  output int   adds_o,
  output int   fetches_o
);

  typedef struct packed {
    logic [7:0] out_char;
    logic       end_of_text;
  } summary_char_t;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0] tally [NUM_BINS];
  int unsigned           next_bin;
  int unsigned           count_shown;
  int unsigned           digits_due;
  summary_char_t         summary_q [$];
  int                    adds;
  int                    fetches;
  int                    markers;

  function automatic bit is_blank(input logic [7:0] b);
    return b == CHR_SPACE || b == CHR_TAB || b == CHR_LF || b == CHR_CR;
  endfunction

  task automatic count_byte(input logic [7:0] b);
    if (!is_blank(b) && int'(b) < NUM_BINS && tally[b] != COUNT_MAX) begin
      tally[b] = tally[b] + 1'b1;
    end
  endtask

  task automatic next_summary_char(output summary_char_t c);
    int unsigned scale;
    int unsigned v;
    c.out_char    = CHR_NUL;
    c.end_of_text = 1'b0;
    if (digits_due > 0) begin
      scale = 1;
      for (int k = 1; k < digits_due; k++) begin
        scale = scale * 10;
      end
      c.out_char = CHR_ZERO + 8'((count_shown / scale) % 10);
      digits_due = digits_due - 1;
    end else begin
      while (next_bin < NUM_BINS && tally[next_bin] == '0) begin
        next_bin = next_bin + 1;
      end
      if (next_bin < NUM_BINS) begin
        c.out_char  = 8'(next_bin);
        count_shown = tally[next_bin];
        digits_due  = 1;
        v = count_shown;
        while (v >= 10) begin
          v = v / 10;
          digits_due = digits_due + 1;
        end
        tally[next_bin] = '0;
        next_bin = next_bin + 1;
      end else begin
        next_bin      = 0;
        c.end_of_text = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    summary_char_t want;
    summary_char_t got;
    int            errs;
    errs = 0;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        tally[i] = '0;
      end
      next_bin    = 0;
      count_shown = 0;
      digits_due  = 0;
      adds        = 0;
      fetches     = 0;
      markers     = 0;
      summary_q.delete();
      fail_count_o  <= 0;
      pending_o     <= 0;
      markers_due_o <= 0;
      adds_o        <= 0;
      fetches_o     <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        got.out_char    = out_i.out_char;
        got.end_of_text = out_i.end_of_text;
        if (summary_q.size() == 0) begin
          $error("Summary word with nothing expected: out_char %02h, end_of_text %0b.",
                 got.out_char, got.end_of_text);
          errs++;
        end else begin
          want = summary_q.pop_front();
          if (got.out_char !== want.out_char) begin
            $error("out_char: expected %02h, got %02h.", want.out_char, got.out_char);
            errs++;
          end
          if (got.end_of_text !== want.end_of_text) begin
            $error("end_of_text: expected %0b, got %0b.", want.end_of_text, got.end_of_text);
            errs++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (in_i.action == ACT_ADD) begin
          count_byte(in_i.byte_value);
          adds++;
        end else begin
          next_summary_char(want);
          summary_q.push_back(want);
          fetches++;
          if (want.end_of_text) begin
            markers++;
          end
        end
      end
      fail_count_o  <= fail_count_o + errs;
      pending_o     <= summary_q.size();
      markers_due_o <= markers;
      adds_o        <= adds;
      fetches_o     <= fetches;
    end
  end

endmodule

[sim/char_histogram_count_text_test.sv]
module char_histogram_count_text_test;
  import chc_pkg::*;

  localparam int COUNT_BITS   = 11;
  localparam int NUM_BINS     = 256;
  localparam int RANDOM_ITEMS = 1450;
  localparam int IDLE_PCT     = 13;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 2_000_000;

  localparam int TEXT_ANY    = 0;
  localparam int TEXT_FEW    = 1;
  localparam int TEXT_SPACED = 2;

  localparam logic [7:0] SEED_TEXT [8] = '{
    CHR_NUL, CHR_NUL, 8'hFF, CHR_SPACE, CHR_TAB, CHR_LF, CHR_CR, 8'h80
  };

  logic clk_i;
  logic rst_ni;

  chc_in_if  in_w ();
  chc_out_if out_w ();

  int fail_count;
  int pending;
  int markers_due;
  int adds;
  int fetches;
  int words_sent;
  int cycles;
  int hold_token;
  int hold_served;
  bit steady;

  char_histogram_count_text #(
    .COUNT_BITS(COUNT_BITS),
    .NUM_BINS  (NUM_BINS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_w),
    .out_o (out_w)
  );

  char_histogram_count_text_checker #(
    .COUNT_BITS(COUNT_BITS),
    .NUM_BINS  (NUM_BINS)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_w),
    .out_i        (out_w),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .markers_due_o(markers_due),
    .adds_o       (adds),
    .fetches_o    (fetches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("char_histogram_count_text_test: done, errors");
    $finish;
  end

  // The receiver stalls at random, and holds off for a long stretch on request.
  initial begin
    out_w.ready <= 1'b0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_token) begin
        out_w.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_served = hold_token;
      end else begin
        out_w.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_word(input logic act, input logic [7:0] b);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_w.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_w.valid      <= 1'b1;
    in_w.action     <= act;
    in_w.byte_value <= b;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic drain();
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_text(input int len, input int flavor);
    logic [7:0] letters [4];
    logic [7:0] b;
    for (int i = 0; i < 4; i++) begin
      letters[i] = 8'($urandom_range(255));
    end
    repeat (len) begin
      case (flavor)
        TEXT_FEW: begin
          b = letters[$urandom_range(3)];
        end
        TEXT_SPACED: begin
          case ($urandom_range(5))
            0: b = CHR_SPACE;
            1: b = CHR_TAB;
            2: b = CHR_LF;
            3: b = CHR_CR;
            default: b = letters[$urandom_range(3)];
          endcase
        end
        default: begin
          b = 8'($urandom_range(255));
        end
      endcase
      send_word(ACT_ADD, b);
    end
  endtask

  // Fetches until the end marker is due, with random adds (add_pct percent) mixed into the read-out.
  task automatic read_summary(input int add_pct);
    int start;
    start = markers_due;
    while (markers_due == start) begin
      if ($urandom_range(99) < add_pct) begin
        send_word(ACT_ADD, 8'($urandom_range(255)));
      end else begin
        send_word(ACT_FETCH, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    int target;
    int string_no;
    int kind;
    rst_ni          <= 1'b0;
    in_w.valid      <= 1'b0;
    in_w.action     <= ACT_ADD;
    in_w.byte_value <= CHR_NUL;
    steady          <= 1'b0;
    hold_token      <= 0;
    words_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(ACT_FETCH, 8'hFF);
    foreach (SEED_TEXT[i]) begin
      send_word(ACT_ADD, SEED_TEXT[i]);
    end
    repeat (2) send_word(ACT_FETCH, 8'($urandom_range(255)));
    send_word(ACT_ADD, CHR_NUL);
    send_word(ACT_ADD, 8'h7F);
    repeat (10) send_word(ACT_FETCH, 8'($urandom_range(255)));
    drain();

    target = RANDOM_ITEMS;
    string_no = 0;
    while (words_sent < target) begin
      string_no++;
      if (string_no == 10) begin
        hold_token <= hold_token + 1;
        write_text(40, TEXT_ANY);
        read_summary(5);
      end
      if (string_no == 20) begin
        steady <= 1'b1;
      end
      if (string_no == 32) begin
        steady <= 1'b0;
      end
      if (string_no % 15 == 0) begin
        drain();
      end
      kind = $urandom_range(99);
      if (kind < 70) begin
        write_text($urandom_range(0, 24), $urandom_range(TEXT_ANY, TEXT_SPACED));
        read_summary($urandom_range(0, 12));
      end else if (kind < 73) begin
        write_text($urandom_range(150, 400), TEXT_FEW);
        read_summary(3);
      end else if (kind < 87) begin
        repeat ($urandom_range(1, 12)) begin
          send_word(logic'($urandom_range(1)), 8'($urandom_range(255)));
        end
      end else begin
        write_text($urandom_range(1, 10), TEXT_ANY);
        repeat ($urandom_range(1, 4)) send_word(ACT_FETCH, 8'($urandom_range(255)));
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    $display("Sent %0d words: %0d adds and %0d fetches over %0d texts, %0d read-outs ended.",
             words_sent, adds, fetches, string_no, markers_due);
    $display("Covered blank skipping, repeated symbols, adds during read-out and long stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("char_histogram_count_text_test: done, clean");
    end else begin
      $display("char_histogram_count_text_test: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/chc_pkg.sv
design/chc_if.sv
design/chc_ram.sv
design/chc_bcd.sv
design/char_histogram_count_text.sv
design/chc_checker.sv
sim/char_histogram_count_text_checker.sv
sim/char_histogram_count_text_test.sv
